>>> sv/tcce_pkg.sv
// Package for the text console character engine.
// Holds the transaction structs, operation and state codes and character constants.
// No dependencies.
package tcce_pkg;

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_GOTO  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_BLANK
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  char_code;
    logic [6:0]  goto_col;
    logic [4:0]  goto_row;
    logic [10:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_item_t;

  // Outcome of one put on the cursor.
  typedef struct packed {
    logic       wr_en;
    logic       scroll;
    logic [6:0] col;
    logic [4:0] row;
  } put_step_t;

  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] TAB_STOP   = 8'h08;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

endpackage

>>> sv/tcce_put_step.sv
// Cursor update for one put: control codes, printable advance, column wrap
// and row overflow detection. Depends on tcce_pkg.
module tcce_put_step #(
  parameter int COLUMNS  = 80,
  parameter int LAST_ROW = 24
) (
  input  logic [6:0]          col,
  input  logic [4:0]          row,
  input  logic [7:0]          char_code,
  output tcce_pkg::put_step_t step
);
  import tcce_pkg::*;

  logic [7:0] col_w;
  logic [5:0] row_w;
  logic       wr_w;

  always_comb begin
    col_w = {1'b0, col};
    row_w = {1'b0, row};
    wr_w  = 1'b0;
    case (char_code)
      CH_BS: begin
        if (col != 7'd0) begin
          col_w = col_w - 8'd1;
        end
      end
      CH_TAB: begin
        col_w = (col_w + TAB_STOP) & ~(TAB_STOP - 8'd1);
      end
      CH_CR: begin
        col_w = 8'd0;
      end
      CH_LF: begin
        col_w = 8'd0;
        row_w = row_w + 6'd1;
      end
      default: begin
        if (char_code inside {[CH_SPACE:CH_TILDE]}) begin
          wr_w  = 1'b1;
          col_w = col_w + 8'd1;
        end
      end
    endcase
    // wrap to the next row
    if (col_w >= 8'(COLUMNS)) begin
      col_w = 8'd0;
      row_w = row_w + 6'd1;
    end
    step.wr_en  = wr_w;
    step.scroll = (row_w > 6'(LAST_ROW));
    step.col    = col_w[6:0];
    step.row    = step.scroll ? 5'(LAST_ROW) : row_w[4:0];
  end

endmodule

>>> sv/text_console_char_engine_core.sv
// Top level of the text console character engine: cell store, cursor,
// sweep sequencer for scroll and clear. Depends on tcce_pkg and tcce_put_step.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------------
//  input   | start, busy, in_item           | transaction at start && !busy
//  result  | out_strobe, out_item           | one cycle per result, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_data | write at cfg_valid && cfg_ready
//
// Put without scroll, goto and read leave the block idle; the result shows the cycle
// after the transaction and a new transaction may be taken every cycle.
// A scroll walks the single-port-write cell store: the copy state moves each row
// up one row, then the blank state fills the last row with spaces. Clear blanks all
// CELLS cells. busy is high for the sweep; the result follows it.
// Reset puts the cursor at 0,0 and the attribute at 0x0F; the store is left as is.
// Results cannot be stalled by the receiver.
module text_console_char_engine_core #(
  parameter int COLUMNS  = 80,
  parameter int LAST_ROW = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcce_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output tcce_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * (LAST_ROW + 1);
  localparam int MW    = $clog2(CELLS);       // store index width
  localparam int CW    = $clog2(CELLS + 1);   // sweep pointer, holds CELLS
  localparam int LW    = (CW > 11) ? CW : 11; // linear position arithmetic

  // cell store: one write port, one registered read port
  logic [15:0] mem [CELLS];
  logic [15:0] rd_data_r;
  logic [MW-1:0] mem_ridx;
  logic [MW-1:0] mem_widx;
  logic [15:0] mem_wdata;
  logic        mem_we;

  state_t      state_r, state_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic        pend_r, pend_nxt;       // copy read in flight
  logic [MW-1:0] dst_r, dst_nxt;       // its destination
  logic [6:0]  col_r, col_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic        strobe_r, strobe_nxt;
  logic        scr_r, scr_nxt;
  logic        rdok_r, rdok_nxt;

  put_step_t   put;
  logic        accept;
  logic [LW-1:0] cur_lin;
  logic [LW-1:0] rd_lin;
  logic [CW-1:0] dst_lin;

  tcce_put_step #(
    .COLUMNS (COLUMNS),
    .LAST_ROW(LAST_ROW)
  ) u_put_step (
    .col      (col_r),
    .row      (row_r),
    .char_code(in_item.char_code),
    .step     (put)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cur_lin   = LW'(row_r) * LW'(COLUMNS) + LW'(col_r);
  assign rd_lin    = LW'(in_item.cell_address);
  assign dst_lin   = ptr_r - CW'(COLUMNS);

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    pend_nxt   = 1'b0;
    dst_nxt    = dst_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    attr_nxt   = (cfg_valid && cfg_ready) ? cfg_data : attr_r;
    strobe_nxt = 1'b0;
    scr_nxt    = scr_r;
    rdok_nxt   = rdok_r;
    mem_we     = 1'b0;
    mem_widx   = cur_lin[MW-1:0];
    mem_wdata  = {attr_r, in_item.char_code};
    mem_ridx   = rd_lin[MW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          scr_nxt  = 1'b0;
          rdok_nxt = 1'b0;
          case (in_item.func)
            FUNC_PUT: begin
              // write the cell at the old cursor, then move
              mem_we  = put.wr_en;
              col_nxt = put.col;
              row_nxt = put.row;
              scr_nxt = put.scroll;
              if (put.scroll) begin
                state_nxt = ST_COPY;
                ptr_nxt   = CW'(COLUMNS);
              end else begin
                strobe_nxt = 1'b1;
              end
            end
            FUNC_GOTO: begin
              col_nxt = (in_item.goto_col > 7'(COLUMNS - 1)) ? 7'(COLUMNS - 1)
                                                             : in_item.goto_col;
              row_nxt = (in_item.goto_row > 5'(LAST_ROW)) ? 5'(LAST_ROW)
                                                          : in_item.goto_row;
              strobe_nxt = 1'b1;
            end
            FUNC_CLEAR: begin
              col_nxt   = 7'd0;
              row_nxt   = 5'd0;
              state_nxt = ST_BLANK;
              ptr_nxt   = '0;
            end
            FUNC_READ: begin
              // out-of-range address answers zero
              rdok_nxt   = (rd_lin < LW'(CELLS));
              strobe_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_COPY: begin
        // read one row ahead, write the previous read back one row up
        mem_ridx  = ptr_r[MW-1:0];
        mem_we    = pend_r;
        mem_widx  = dst_r;
        mem_wdata = rd_data_r;
        if (ptr_r == CW'(CELLS)) begin
          state_nxt = ST_BLANK;
          ptr_nxt   = CW'(CELLS - COLUMNS);
        end else begin
          pend_nxt = 1'b1;
          dst_nxt  = dst_lin[MW-1:0];
          ptr_nxt  = ptr_r + CW'(1);
        end
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_widx  = ptr_r[MW-1:0];
        mem_wdata = {attr_r, CH_SPACE};
        ptr_nxt   = ptr_r + CW'(1);
        if (ptr_r == CW'(CELLS - 1)) begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    rd_data_r <= mem[mem_ridx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_r   <= 1'b0;
      col_r    <= 7'd0;
      row_r    <= 5'd0;
      attr_r   <= ATTR_RESET;
      strobe_r <= 1'b0;
      scr_r    <= 1'b0;
      rdok_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      attr_r   <= attr_nxt;
      strobe_r <= strobe_nxt;
      scr_r    <= scr_nxt;
      rdok_r   <= rdok_nxt;
    end
  end

  // sweep pointers carry no control meaning outside a sweep
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    dst_r <= dst_nxt;
  end

  // result: cursor holds through the strobe cycle, read data comes from the store
  assign out_strobe            = strobe_r;
  assign out_item.cursor_index = cur_lin[10:0];
  assign out_item.cell_data    = rdok_r ? rd_data_r : 16'd0;
  assign out_item.scrolled     = scr_r;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe during a sweep");

  a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.func == FUNC_GOTO || in_item.func == FUNC_READ)) |=> out_strobe)
    else $error("goto or read gave no result on the next cycle");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.scrolled) |-> (row_r == 5'(LAST_ROW) && col_r == 7'd0))
    else $error("scroll left the cursor off the start of the last row");
`endif

endmodule

>>> verif/tcce_checker.sv
`timescale 1ns / 1ps
// Checker for text_console_char_engine_core: watches the input, result and config channels.
// Predicts each result from its own console state and compares. Depends on tcce_pkg.
module tcce_checker #(
  parameter int COLUMNS  = 80,
  parameter int LAST_ROW = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  tcce_pkg::in_item_t  in_item,
  input  logic                out_strobe,
  input  tcce_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output int                  mismatches,
  output int                  results
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * (LAST_ROW + 1);

  logic [15:0] screen [CELLS];
  int          cur_col;
  int          cur_row;
  logic [7:0]  attr;
  out_item_t   console_out_q [$];
  int          fail_total = 0;
  int          seen_total = 0;

  assign mismatches = fail_total;
  assign results    = seen_total;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_total++;
  endtask

  // Apply one transaction to the predicted console and return its result.
  task automatic console_step(input in_item_t it, output out_item_t res);
    logic [15:0] data;
    logic        scr;
    int          i;
    data = '0;
    scr  = 1'b0;
    case (it.func)
      FUNC_PUT: begin
        case (it.char_code)
          CH_BS:  if (cur_col > 0) cur_col--;
          CH_TAB: cur_col = (cur_col + int'(TAB_STOP)) & ~(int'(TAB_STOP) - 1);
          CH_CR:  cur_col = 0;
          CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          default: begin
            if (it.char_code >= CH_SPACE && it.char_code <= CH_TILDE) begin
              screen[cur_row * COLUMNS + cur_col] = {attr, it.char_code};
              cur_col++;
            end
          end
        endcase
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row > LAST_ROW) begin
          for (i = 0; i + COLUMNS < CELLS; i++) screen[i] = screen[i + COLUMNS];
          for (; i < CELLS; i++) screen[i] = {attr, CH_SPACE};
          cur_row = LAST_ROW;
          scr     = 1'b1;
        end
      end
      FUNC_GOTO: begin
        cur_col = (int'(it.goto_col) > COLUMNS - 1) ? COLUMNS - 1 : int'(it.goto_col);
        cur_row = (int'(it.goto_row) > LAST_ROW) ? LAST_ROW : int'(it.goto_row);
      end
      FUNC_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {attr, CH_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        if (int'(it.cell_address) < CELLS) data = screen[it.cell_address];
      end
    endcase
    res.cursor_index = 11'(cur_row * COLUMNS + cur_col);
    res.cell_data    = data;
    res.scrolled     = scr;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cur_col = 0;
      cur_row = 0;
      attr    = ATTR_RESET;
      console_out_q.delete();
    end else begin
      // Retire the oldest prediction before taking a new transaction in the same cycle.
      if (out_strobe === 1'b1) begin
        if (console_out_q.size() == 0) begin
          report_mismatch("result with nothing pending", '0, 32'(out_item));
        end else begin
          want = console_out_q.pop_front();
          if (out_item.cursor_index !== want.cursor_index)
            report_mismatch("cursor_index", 32'(want.cursor_index),
                            32'(out_item.cursor_index));
          if (out_item.cell_data !== want.cell_data)
            report_mismatch("cell_data", 32'(want.cell_data), 32'(out_item.cell_data));
          if (out_item.scrolled !== want.scrolled)
            report_mismatch("scrolled", 32'(want.scrolled), 32'(out_item.scrolled));
        end
        seen_total <= seen_total + 1;
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) attr = cfg_data;
      if (start === 1'b1 && busy === 1'b0) begin
        console_step(in_item, want);
        console_out_q.push_back(want);
      end
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for text_console_char_engine_core: clock, reset, stimulus, verdict.
// Depends on tcce_pkg, text_console_char_engine_core and tcce_checker.
module testbench;
  import tcce_pkg::*;

  localparam int COLUMNS  = 80;
  localparam int LAST_ROW = 24;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_item   = '0;
  logic       out_strobe;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  int mismatches;
  int results;
  // Transactions taken by the block so far; compared against the checker's result count.
  int accepted   = 0;
  // Printable characters still owed by a running line burst.
  int burst_left = 0;

  // 2 ns clock.
  always #1 clk = ~clk;

  text_console_char_engine_core #(
    .COLUMNS  (COLUMNS),
    .LAST_ROW (LAST_ROW)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  tcce_checker #(
    .COLUMNS  (COLUMNS),
    .LAST_ROW (LAST_ROW)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .results    (results)
  );

  // Hang guard. The slowest legal run is every transaction forcing a full
  // scroll sweep plus the longest idle gap: about 2.6 ms.
  initial begin
    #10_000_000;
    $display("** text_console_char_engine_core: FAILED **");
    $finish;
  end

  function automatic in_item_t mk(input func_t f, input logic [7:0] ch,
                                  input logic [6:0] gc, input logic [4:0] gr,
                                  input logic [10:0] addr);
    in_item_t it;
    it.func         = f;
    it.char_code    = ch;
    it.goto_col     = gc;
    it.goto_row     = gr;
    it.cell_address = addr;
    return it;
  endfunction

  // Build one random transaction. Fields that the operation ignores carry noise.
  // Most traffic is text and cursor moves that drive wraps and scrolls; line
  // bursts of printable characters run the cursor across whole rows.
  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick;
    it.func         = func_t'($urandom_range(0, 3));
    it.char_code    = 8'($urandom_range(0, 255));
    it.goto_col     = 7'($urandom_range(0, 127));
    it.goto_row     = 5'($urandom_range(0, 31));
    it.cell_address = 11'($urandom_range(0, 2047));
    if (burst_left > 0) begin
      burst_left--;
      it.func      = FUNC_PUT;
      it.char_code = 8'($urandom_range(CH_SPACE, CH_TILDE));
      return it;
    end
    pick = $urandom_range(0, 99);
    if (pick == 0) burst_left = $urandom_range(10, 90);
    if (pick < 40) begin
      it.func      = FUNC_PUT;
      it.char_code = 8'($urandom_range(CH_SPACE, CH_TILDE));
    end else if (pick < 54) begin
      // Control characters; line feed weighted up so rows advance.
      it.func = FUNC_PUT;
      case ($urandom_range(0, 4))
        0:       it.char_code = CH_BS;
        1:       it.char_code = CH_TAB;
        2:       it.char_code = CH_CR;
        default: it.char_code = CH_LF;
      endcase
    end else if (pick < 58) begin
      // Raw byte: mostly ignored controls and high bytes.
      it.func = FUNC_PUT;
    end else if (pick < 70) begin
      it.func = FUNC_GOTO;
      case ($urandom_range(0, 3))
        0: ;  // keep the full field range so saturation is hit
        1: begin
          it.goto_col = 7'($urandom_range(COLUMNS - 8, COLUMNS - 1));
          it.goto_row = 5'($urandom_range(LAST_ROW - 2, LAST_ROW));
        end
        default: begin
          it.goto_col = 7'($urandom_range(0, COLUMNS - 1));
          it.goto_row = 5'($urandom_range(0, LAST_ROW));
        end
      endcase
    end else if (pick < 97) begin
      it.func = FUNC_READ;
      if ($urandom_range(0, 7) == 0)
        it.cell_address = 11'($urandom_range(2000, 2047));
      else
        it.cell_address = 11'($urandom_range(0, 1999));
    end else begin
      it.func = FUNC_CLEAR;
    end
    return it;
  endfunction

  // Hold start and the transaction until the block takes it.
  task automatic send_item(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    accepted++;
  endtask

  // Drop start for an idle gap set by n.
  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Pause the sender until every pending result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (results != accepted) @(posedge clk);
  endtask

  // Write the attribute register, only once the block is idle.
  task automatic write_attr(input logic [7:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_item_t   dir_items [25];
    logic [7:0] attr_value;
    int         drain;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the reset attribute. The store is undefined until
    // written, so the only read before the clear is out of range.
    dir_items = '{
      mk(FUNC_READ,  8'h00,  7'd0,   5'd0,  11'd2047),  // out of range, before any write
      mk(FUNC_CLEAR, 8'h00,  7'd0,   5'd0,  11'd0),
      mk(FUNC_READ,  8'h00,  7'd0,   5'd0,  11'd0),     // blank cell, reset attribute
      mk(FUNC_PUT,   8'h41,  7'd0,   5'd0,  11'd0),
      mk(FUNC_PUT,   CH_SPACE, 7'd0, 5'd0,  11'd0),
      mk(FUNC_PUT,   CH_TILDE, 7'd0, 5'd0,  11'd0),
      mk(FUNC_PUT,   8'h7F,  7'd0,   5'd0,  11'd0),     // ignored bytes from here
      mk(FUNC_PUT,   8'h1F,  7'd0,   5'd0,  11'd0),
      mk(FUNC_PUT,   8'h80,  7'd0,   5'd0,  11'd0),
      mk(FUNC_PUT,   8'hFF,  7'd0,   5'd0,  11'd0),
      mk(FUNC_PUT,   8'h00,  7'd0,   5'd0,  11'd0),
      mk(FUNC_READ,  8'h00,  7'd0,   5'd0,  11'd1),
      mk(FUNC_PUT,   CH_BS,  7'd0,   5'd0,  11'd0),     // backspace from column 3
      mk(FUNC_PUT,   CH_CR,  7'd0,   5'd0,  11'd0),
      mk(FUNC_PUT,   CH_BS,  7'd0,   5'd0,  11'd0),     // backspace at column 0
      mk(FUNC_PUT,   CH_TAB, 7'd0,   5'd0,  11'd0),
      mk(FUNC_GOTO,  8'h00,  7'd127, 5'd31, 11'd0),     // saturates to the last cell
      mk(FUNC_PUT,   8'h5A,  7'd0,   5'd0,  11'd0),     // wrap past the last row: scroll
      mk(FUNC_READ,  8'h00,  7'd0,   5'd0,  11'd1919),  // the character moved up a row
      mk(FUNC_GOTO,  8'h00,  7'd79,  5'd10, 11'd0),
      mk(FUNC_PUT,   CH_TAB, 7'd0,   5'd0,  11'd0),     // tab off the last column wraps
      mk(FUNC_GOTO,  8'h00,  7'd0,   5'd24, 11'd0),
      mk(FUNC_PUT,   CH_LF,  7'd0,   5'd0,  11'd0),     // line feed on the last row scrolls
      mk(FUNC_READ,  8'h00,  7'd0,   5'd0,  11'd2000),  // first address out of range
      mk(FUNC_GOTO,  8'h00,  7'd0,   5'd0,  11'd0)
    };
    foreach (dir_items[i]) begin
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 8));
      send_item(dir_items[i]);
    end

    // Random phases, each under its own attribute. The first two take the
    // extremes; the last one runs with no sender idling at all.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       attr_value = 8'hFF;
        1:       attr_value = 8'h00;
        default: attr_value = 8'($urandom_range(0, 255));
      endcase
      write_attr(attr_value);
      for (int n = 0; n < 126; n++) begin
        if (ph < 4 && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 8));
        send_item(rand_item());
      end
    end

    // Drain: the longest tail is one scroll sweep.
    start <= 1'b0;
    for (drain = 0; drain < 5000 && results != accepted; drain++) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && results == accepted) begin
      $display("** text_console_char_engine_core: PASSED **");
    end else begin
      $display("** text_console_char_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
